// File: hdl/fixed_point_decimal_formatter_macros.svh
// ---------------------------------------------------------------------------
// Fixed-point decimal formatter: assertion macros
// Clocked on clk, disabled while rst_n is low. Empty under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_DECIMAL_FORMATTER_MACROS_SVH
`define FIXED_POINT_DECIMAL_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge
`define FPDF_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// ante at one edge implies cons at the same edge
`define FPDF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante at one edge implies cons at the next edge
`define FPDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FPDF_ASSERT_ALWAYS(label, expr, msg)
`define FPDF_ASSERT_IMPL(label, ante, cons, msg)
`define FPDF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hdl/fpdf_pkg.sv
// ---------------------------------------------------------------------------
// fpdf_pkg
// Shared types, codes and constants of the fixed-point decimal formatter.
// ---------------------------------------------------------------------------
package fpdf_pkg;

  // character sequence
  localparam logic [2:0] LAST_IDX   = 3'd6;
  localparam logic [2:0] MAX_PLACES = 3'd6;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // configuration register indexes
  localparam logic [1:0] REG_DECIMAL_PLACES = 2'd0;
  localparam logic [1:0] REG_UNSIGNED_MODE  = 2'd1;
  localparam logic [1:0] REG_DECIMAL_MARK   = 2'd2;

  // configuration reset values
  localparam logic [2:0] RST_DECIMAL_PLACES = 3'd4;
  localparam logic       RST_UNSIGNED_MODE  = 1'b1;
  localparam logic [7:0] RST_DECIMAL_MARK   = 8'd44;

  typedef struct packed {
    logic [2:0] mark_pos;       // output slot that carries the decimal mark
    logic       unsigned_mode;
    logic [7:0] mark;
  } fmt_cfg_t;

  // d * 10^pow_idx, pow_idx 0..4, d 0..9
  function automatic logic [16:0] digit_weight(input logic [2:0] pow_idx,
                                               input logic [3:0] d);
    logic [16:0] base;
    logic [20:0] prod;
    case (pow_idx)
      3'd0:    base = 17'd1;
      3'd1:    base = 17'd10;
      3'd2:    base = 17'd100;
      3'd3:    base = 17'd1000;
      default: base = 17'd10000;
    endcase
    prod = base * {13'd0, d};
    return prod[16:0];
  endfunction

endpackage

// File: hdl/fpdf_cfg_regs.sv
// ---------------------------------------------------------------------------
// fpdf_cfg_regs
// Configuration registers; derives the slot of the decimal mark.
// ---------------------------------------------------------------------------
module fpdf_cfg_regs import fpdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  output fmt_cfg_t   fmt
);

  logic [2:0] places_r, places_nxt;
  logic       unsigned_r, unsigned_nxt;
  logic [7:0] mark_r, mark_nxt;
  logic [2:0] places_clamped;

  always_comb begin
    places_nxt   = places_r;
    unsigned_nxt = unsigned_r;
    mark_nxt     = mark_r;
    if (wr_en) begin
      case (wr_index)
        REG_DECIMAL_PLACES: places_nxt   = wr_data[2:0];
        REG_UNSIGNED_MODE:  unsigned_nxt = wr_data[0];
        REG_DECIMAL_MARK:   mark_nxt     = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      places_r   <= RST_DECIMAL_PLACES;
      unsigned_r <= RST_UNSIGNED_MODE;
      mark_r     <= RST_DECIMAL_MARK;
    end else begin
      places_r   <= places_nxt;
      unsigned_r <= unsigned_nxt;
      mark_r     <= mark_nxt;
    end
  end

  // seven places acts as six
  assign places_clamped     = (places_r > MAX_PLACES) ? MAX_PLACES : places_r;
  assign fmt.mark_pos       = LAST_IDX - places_clamped;
  assign fmt.unsigned_mode  = unsigned_r;
  assign fmt.mark           = mark_r;

endmodule

// File: hdl/fpdf_digit_step.sv
// ---------------------------------------------------------------------------
// fpdf_digit_step
// Extracts one decimal digit, most significant first, and the remainder.
// ---------------------------------------------------------------------------
module fpdf_digit_step import fpdf_pkg::*; (
  input  logic [15:0] rem,
  input  logic [2:0]  pow_idx,
  output logic [3:0]  digit,
  output logic [15:0] rem_out
);

  always_comb begin
    logic [16:0] sub_val;
    digit   = 4'd0;
    sub_val = 17'd0;
    // parallel compares against 1..9 times the weight; highest hit wins
    for (int d = 1; d <= 9; d++) begin
      if ({1'b0, rem} >= digit_weight(pow_idx, 4'(d))) begin
        digit   = 4'(d);
        sub_val = digit_weight(pow_idx, 4'(d));
      end
    end
    rem_out = rem - sub_val[15:0];
  end

endmodule

// File: hdl/fixed_point_decimal_formatter.sv
// ---------------------------------------------------------------------------
// fixed_point_decimal_formatter
// Prints a 16-bit value as seven ASCII characters with a decimal mark.
// ---------------------------------------------------------------------------
// Usage:
//   A value is taken on in_value at a clock edge where start is high and
//   busy is low. The block then emits seven characters, one per cycle, on
//   out_character, each marked by out_strobe for exactly one cycle;
//   out_last flags the seventh. The sign and five digits with leading
//   zeros follow in that order, with the decimal mark put into the slot
//   chosen by decimal_places; with six places the mark precedes the sign.
//   Characters are registered in char_r from the sequencer state. The
//   rate of values is set by the single character output; busy drops in
//   the cycle before the last character appears, so the next value
//   follows without a gap. One digit is extracted per cycle, except in
//   the sign and mark slots, by a compare-and-subtract step.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Write only while no value is in flight.
//   Reset (rst_n low, synchronous): sequencer idle, no strobe, registers
//   back to 4 places, unsigned mode, comma as mark.
//   The receiver cannot stall; characters are never held.
// ---------------------------------------------------------------------------
`include "fixed_point_decimal_formatter_macros.svh"

module fixed_point_decimal_formatter import fpdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_value,
  // result channel
  output logic        out_strobe,
  output logic [7:0]  out_character,
  output logic        out_last,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  fmt_cfg_t fmt;

  logic        active_r, active_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        neg_r, neg_nxt;

  logic        strobe_r, strobe_nxt;
  logic [7:0]  char_r, char_nxt;
  logic        last_r, last_nxt;

  logic        accept;
  logic        is_neg;
  logic [15:0] mag;
  logic [2:0]  t_pos;
  logic        is_mark;
  logic        is_sign;
  logic        emit_digit;
  logic [2:0]  pow_idx;
  logic [3:0]  digit_w;
  logic [15:0] rem_after;

  assign cfg_ready = 1'b1;

  fpdf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .fmt      (fmt)
  );

  fpdf_digit_step u_digit (
    .rem     (rem_r),
    .pow_idx (pow_idx),
    .digit   (digit_w),
    .rem_out (rem_after)
  );

  assign busy   = active_r && (cnt_r != LAST_IDX);
  assign accept = start && !busy;

  // -32768 wraps to 0x8000, which is its magnitude
  assign is_neg = !fmt.unsigned_mode && in_value[15];
  assign mag    = is_neg ? (~in_value + 16'd1) : in_value;

  // text slot behind the current output slot
  assign t_pos      = (cnt_r < fmt.mark_pos) ? cnt_r : (cnt_r - 3'd1);
  assign is_mark    = (cnt_r == fmt.mark_pos);
  assign is_sign    = !is_mark && (t_pos == 3'd0);
  assign emit_digit = !is_mark && !is_sign;
  assign pow_idx    = 3'd5 - t_pos;

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    neg_nxt    = neg_r;
    if (accept) begin
      active_nxt = 1'b1;
      cnt_nxt    = 3'd0;
      rem_nxt    = mag;
      neg_nxt    = is_neg;
    end else if (active_r) begin
      if (cnt_r == LAST_IDX) begin
        active_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 3'd1;
      end
      if (emit_digit) begin
        rem_nxt = rem_after;
      end
    end
  end

  always_comb begin
    strobe_nxt = active_r;
    last_nxt   = active_r && (cnt_r == LAST_IDX);
    if (is_mark) begin
      char_nxt = fmt.mark;
    end else if (is_sign) begin
      char_nxt = neg_r ? CHAR_MINUS : CHAR_PLUS;
    end else begin
      char_nxt = CHAR_ZERO + {4'd0, digit_w};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= 3'd0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_character = char_r;
  assign out_last      = last_r;

  `FPDF_ASSERT_NEXT(a_accept_restarts, accept, active_r && cnt_r == 3'd0, "no restart")
  `FPDF_ASSERT_NEXT(a_last_follows, active_r && cnt_r == LAST_IDX, out_strobe && out_last, "no last")
  `FPDF_ASSERT_ALWAYS(a_last_strobed, !out_last || out_strobe, "last without strobe")
  `FPDF_ASSERT_IMPL(a_digit_range, active_r && emit_digit, digit_w <= 4'd9, "digit out of range")
  `FPDF_ASSERT_IMPL(a_rem_drained, active_r && cnt_r == LAST_IDX, rem_r < 16'd10, "digits left over")

endmodule
